// ===== sv/slte_pkg.sv =====
package slte_pkg;

    localparam int KEY_W   = 16;
    localparam int DATA_W  = 32;
    localparam int POS_W   = 5;
    localparam int COUNT_W = 6;
    localparam int MODE_W  = 2;

    typedef enum logic [MODE_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_GET    = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        STATUS_OK      = 3'd0,
        STATUS_FULL    = 3'd1,
        STATUS_EMPTY   = 3'd2,
        STATUS_MISSING = 3'd3,
        STATUS_RANGE   = 3'd4
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [KEY_W-1:0]   key;
        logic [DATA_W-1:0]  payload;
        logic [POS_W-1:0]   position;
    } t_request;

    typedef struct packed {
        t_status            status;
        logic [DATA_W-1:0]  found_payload;
        logic [KEY_W-1:0]   found_key;
        logic [COUNT_W-1:0] count;
    } t_result;

    typedef struct packed {
        t_op              op;
        logic             flag;
        logic             cvalid;
        logic [POS_W-1:0] pos;
    } t_wave_ctrl;

endpackage

// ===== sv/slte_cell.sv =====
module slte_cell #(
    parameter int KB = 16,
    parameter int DB = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_go,
    input  slte_pkg::t_wave_ctrl i_ctrl,
    input  logic [KB-1:0]        i_key,
    input  logic [DB-1:0]        i_data,
    input  logic                 i_nbr_valid,
    input  logic [KB-1:0]        i_nbr_key,
    input  logic [DB-1:0]        i_nbr_data,
    output logic                 o_go,
    output slte_pkg::t_wave_ctrl o_ctrl,
    output logic [KB-1:0]        o_key,
    output logic [DB-1:0]        o_data,
    output logic                 o_valid,
    output logic [KB-1:0]        o_entry_key,
    output logic [DB-1:0]        o_entry_data
);
    import slte_pkg::*;

    logic          r_valid, n_valid;
    logic [KB-1:0] r_ekey, n_ekey;
    logic [DB-1:0] r_edata, n_edata;
    logic          r_go;
    t_wave_ctrl    r_ctrl, n_ctrl;
    logic [KB-1:0] r_tkey, n_tkey;
    logic [DB-1:0] r_tdata, n_tdata;

    always_comb begin
        n_valid = r_valid;
        n_ekey  = r_ekey;
        n_edata = r_edata;
        n_ctrl  = i_ctrl;
        n_tkey  = i_key;
        n_tdata = i_data;
        if (i_go) begin
            case (i_ctrl.op)
                OP_INSERT: begin
                    if (i_ctrl.cvalid && (i_ctrl.flag || !r_valid || (i_key < r_ekey))) begin
                        n_valid       = 1'b1;
                        n_ekey        = i_key;
                        n_edata       = i_data;
                        n_tkey        = r_ekey;
                        n_tdata       = r_edata;
                        n_ctrl.cvalid = r_valid;
                        n_ctrl.flag   = 1'b1;
                    end
                end
                OP_REMOVE: begin
                    if (i_ctrl.flag || (r_valid && (r_ekey == i_key))) begin
                        n_valid     = i_nbr_valid;
                        n_ekey      = i_nbr_key;
                        n_edata     = i_nbr_data;
                        n_ctrl.flag = 1'b1;
                    end
                end
                OP_GET: begin
                    if (!i_ctrl.flag) begin
                        if (i_ctrl.pos == '0) begin
                            n_tkey      = r_ekey;
                            n_tdata     = r_edata;
                            n_ctrl.flag = 1'b1;
                        end else begin
                            n_ctrl.pos = i_ctrl.pos - POS_W'(1);
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_go    <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_go    <= i_go;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ekey  <= n_ekey;
        r_edata <= n_edata;
        r_ctrl  <= n_ctrl;
        r_tkey  <= n_tkey;
        r_tdata <= n_tdata;
    end

    assign o_go         = r_go;
    assign o_ctrl       = r_ctrl;
    assign o_key        = r_tkey;
    assign o_data       = r_tdata;
    assign o_valid      = r_valid;
    assign o_entry_key  = r_ekey;
    assign o_entry_data = r_edata;

endmodule

// ===== sv/sorted_list_table_engine.sv =====
// Channel   Ports                     Handshake
// request   start, busy, i_req        taken when start is high and busy is low
// result    o_done, o_result          one-cycle strobe, receiver always takes it
//
// A request passes a launch register, the register of each cell as the
// operation wave crosses the row of cells, and then the result register.
// busy drops with the result strobe, so the next request may start then.
// Reset empties every cell at once; no clearing pass.
// Results cannot be stalled.
module sorted_list_table_engine #(
    parameter int CAPACITY  = 32,
    parameter int KEY_BITS  = 16,
    parameter int DATA_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  slte_pkg::t_request i_req,
    output logic               o_done,
    output slte_pkg::t_result  o_result
);
    import slte_pkg::*;

    localparam int KB = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
    localparam int DB = (DATA_BITS < DATA_W) ? DATA_BITS : DATA_W;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;

    t_state        r_state, n_state;
    logic          accept, finish;

    logic          r_go;
    t_wave_ctrl    r_ctrl, n_ctrl;
    logic [KB-1:0] r_key;
    logic [DB-1:0] r_data;
    t_status       r_status, n_status;
    t_op           r_op;
    logic [CW-1:0] r_count, n_count;
    logic          r_done;
    t_result       r_result, n_result;

    logic          go   [0:CAPACITY];
    t_wave_ctrl    ctrl [0:CAPACITY];
    logic [KB-1:0] tkey [0:CAPACITY];
    logic [DB-1:0] tdata[0:CAPACITY];
    logic          ev   [0:CAPACITY];
    logic [KB-1:0] ek   [0:CAPACITY];
    logic [DB-1:0] ed   [0:CAPACITY];

    assign go[0]         = r_go;
    assign ctrl[0]       = r_ctrl;
    assign tkey[0]       = r_key;
    assign tdata[0]      = r_data;
    assign ev[CAPACITY]  = 1'b0;
    assign ek[CAPACITY]  = '0;
    assign ed[CAPACITY]  = '0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        slte_cell #(
            .KB(KB),
            .DB(DB)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_go        (go[g]),
            .i_ctrl      (ctrl[g]),
            .i_key       (tkey[g]),
            .i_data      (tdata[g]),
            .i_nbr_valid (ev[g+1]),
            .i_nbr_key   (ek[g+1]),
            .i_nbr_data  (ed[g+1]),
            .o_go        (go[g+1]),
            .o_ctrl      (ctrl[g+1]),
            .o_key       (tkey[g+1]),
            .o_data      (tdata[g+1]),
            .o_valid     (ev[g]),
            .o_entry_key (ek[g]),
            .o_entry_data(ed[g])
        );
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (go[CAPACITY]) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        busy   = 1'b0;
        accept = 1'b0;
        finish = 1'b0;
        unique case (r_state)
            S_IDLE: accept = start;
            S_RUN: begin
                busy   = 1'b1;
                finish = go[CAPACITY];
            end
            default: busy = 1'b0;
        endcase
    end

    // decide early outcome and launch the wave
    always_comb begin
        n_ctrl        = '0;
        n_ctrl.op     = OP_NONE;
        n_ctrl.cvalid = 1'b1;
        n_ctrl.pos    = i_req.position;
        n_status      = STATUS_OK;
        case (t_op'(i_req.mode))
            OP_INSERT: begin
                if (r_count == CW'(CAPACITY)) begin
                    n_status = STATUS_FULL;
                end else begin
                    n_ctrl.op = OP_INSERT;
                end
            end
            OP_REMOVE: begin
                if (r_count == '0) begin
                    n_status = STATUS_EMPTY;
                end else begin
                    n_ctrl.op = OP_REMOVE;
                end
            end
            OP_GET: begin
                if (PW'(i_req.position) >= PW'(r_count)) begin
                    n_status = STATUS_RANGE;
                end else begin
                    n_ctrl.op = OP_GET;
                end
            end
            default: n_ctrl.op = OP_NONE;
        endcase
    end

    always_comb begin
        n_count           = r_count;
        n_result          = '0;
        n_result.status   = r_status;
        case (r_op)
            OP_INSERT: n_count = r_count + CW'(1);
            OP_REMOVE: begin
                if (ctrl[CAPACITY].flag) begin
                    n_count = r_count - CW'(1);
                end else begin
                    n_result.status = STATUS_MISSING;
                end
            end
            OP_GET: begin
                n_result.found_key     = KEY_W'(tkey[CAPACITY]);
                n_result.found_payload = DATA_W'(tdata[CAPACITY]);
            end
            default: n_count = r_count;
        endcase
        n_result.count = COUNT_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_go    <= 1'b0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_go    <= accept;
            r_done  <= finish;
            if (finish) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ctrl   <= n_ctrl;
            r_key    <= i_req.key[KB-1:0];
            r_data   <= i_req.payload[DB-1:0];
            r_status <= n_status;
            r_op     <= n_ctrl.op;
        end
        if (finish) begin
            r_result <= n_result;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    logic [CAPACITY:0] go_vec;
    for (genvar g = 0; g <= CAPACITY; g++) begin : g_go_vec
        assign go_vec[g] = go[g];
    end

    a_one_wave: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(go_vec))
        else $error("more than one operation wave in the cell row");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count beyond capacity");

    a_launch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && r_go))
        else $error("request accepted without launching a wave");

    a_done_after_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(busy) && !busy))
        else $error("result strobe without a finished request");

endmodule
